>>> design/fdf_pkg.sv
// ----------------------------------------------------------------------------
// fdf_pkg
// shared types, codes and constants of the fall detector
// ----------------------------------------------------------------------------
package fdf_pkg;

  // operation codes carried in the input tuser
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;

  // result event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_START   = 3'd1;
  localparam logic [2:0] EV_STEP    = 3'd2;
  localparam logic [2:0] EV_FALL    = 3'd3;
  localparam logic [2:0] EV_CANCEL  = 3'd4;

  // detector phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_RUN     = 3'd1;
  localparam logic [2:0] PH_IMPACT  = 3'd2;
  localparam logic [2:0] PH_STILL   = 3'd3;
  localparam logic [2:0] PH_RECHECK = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_BAND_LOW         = 3'd0;
  localparam logic [2:0] CFG_BAND_HIGH        = 3'd1;
  localparam logic [2:0] CFG_BAND_MIN_RUN     = 3'd2;
  localparam logic [2:0] CFG_IMPACT_THRESHOLD = 3'd3;
  localparam logic [2:0] CFG_IMPACT_WINDOW    = 3'd4;
  localparam logic [2:0] CFG_STILL_THRESHOLD  = 3'd5;
  localparam logic [2:0] CFG_STILL_WINDOW     = 3'd6;
  localparam logic [2:0] CFG_COUNTDOWN_LENGTH = 3'd7;

  localparam logic [12:0] ONE_G = 13'd1000;

  // reset values of the registers
  localparam logic [12:0] RST_BAND_LOW         = 13'd800;
  localparam logic [12:0] RST_BAND_HIGH        = 13'd1000;
  localparam logic [7:0]  RST_BAND_MIN_RUN     = 8'd4;
  localparam logic [12:0] RST_IMPACT_THRESHOLD = 13'd500;
  localparam logic [7:0]  RST_IMPACT_WINDOW    = 8'd25;
  localparam logic [12:0] RST_STILL_THRESHOLD  = 13'd100;
  localparam logic [7:0]  RST_STILL_WINDOW     = 8'd50;
  localparam logic [3:0]  RST_COUNTDOWN_LENGTH = 4'd10;

  typedef struct packed {
    logic [12:0] band_low;
    logic [12:0] band_high;
    logic [7:0]  band_min_run;
    logic [12:0] impact_threshold;
    logic [7:0]  impact_window;
    logic [12:0] still_threshold;
    logic [7:0]  still_window;
    logic [3:0]  countdown_length;
  } cfg_t;

  // one classified item between front and back
  typedef struct packed {
    logic [1:0]  op;
    logic [25:0] sumsq;
  } qitem_t;

  typedef struct packed {
    logic        done;
    logic [12:0] root;
    logic        exact;
  } sqrt_res_t;

  function automatic logic [7:0] inc8(input logic [7:0] c);
    logic [7:0] r;
    r = (c == 8'hff) ? c : c + 8'd1;
    return r;
  endfunction

endpackage

>>> design/fdf_front.sv
// ----------------------------------------------------------------------------
// fdf_front
// accepts items, takes magnitudes and forms the sum of squares of a sample
// ----------------------------------------------------------------------------
module fdf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  logic signed [12:0]  accel_x,
  input  logic signed [12:0]  accel_y,
  input  logic signed [12:0]  accel_z,
  output logic                q_valid,
  input  logic                q_ready,
  output fdf_pkg::qitem_t     q_item
);
  import fdf_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_SQUARE, F_PUSH} fstate_t;

  fstate_t     state;
  logic [1:0]  op;
  logic [12:0] mag [3];
  logic [1:0]  sq_idx;
  logic [25:0] acc;
  logic [25:0] sq;

  function automatic logic [12:0] abs13(input logic signed [12:0] a);
    logic [12:0] r;
    r = a[12] ? 13'(-a) : 13'(a);
    return r;
  endfunction

  assign in_ready = (state == F_IDLE);
  assign sq       = 26'(mag[sq_idx]) * 26'(mag[sq_idx]);
  assign q_valid  = (state == F_PUSH);
  assign q_item   = '{op: op, sumsq: acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      sq_idx <= '0;
      acc    <= '0;
      op     <= OP_SAMPLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            op     <= operation;
            mag[0] <= abs13(accel_x);
            mag[1] <= abs13(accel_y);
            mag[2] <= abs13(accel_z);
            acc    <= '0;
            sq_idx <= '0;
            state  <= (operation == OP_SAMPLE) ? F_SQUARE : F_PUSH;
          end
        end
        F_SQUARE: begin
          acc    <= acc + sq;
          sq_idx <= sq_idx + 2'd1;
          if (sq_idx == 2'd2) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (q_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> design/fdf_queue.sv
// ----------------------------------------------------------------------------
// fdf_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module fdf_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  fdf_pkg::qitem_t wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output fdf_pkg::qitem_t rd_item
);
  import fdf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  qitem_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

>>> design/fdf_isqrt.sv
// ----------------------------------------------------------------------------
// fdf_isqrt
// iterative integer square root over 26 bits, one result bit per cycle
// ----------------------------------------------------------------------------
module fdf_isqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [25:0]         n,
  output fdf_pkg::sqrt_res_t  res
);
  import fdf_pkg::*;

  logic [25:0] rem;
  logic [25:0] root;
  logic [25:0] bitv;
  logic [25:0] trial;
  logic        busy;
  logic        done;

  assign trial = root + bitv;
  assign res   = '{done: done, root: root[12:0], exact: (rem == '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rem  <= '0;
      root <= '0;
      bitv <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= n;
        root <= '0;
        bitv <= 26'h100_0000;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        // the step with the lowest bit is the last one
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("square root started while busy");

endmodule

>>> design/fdf_back.sv
// ----------------------------------------------------------------------------
// fdf_back
// takes classified items, runs the root and the detector, holds the result
// ----------------------------------------------------------------------------
module fdf_back (
  input  logic                clk,
  input  logic                rst,
  input  fdf_pkg::cfg_t       cfg,
  input  logic                q_valid,
  output logic                q_ready,
  input  fdf_pkg::qitem_t     q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          event_res,
  output logic [3:0]          countdown_shown,
  output logic [12:0]         deviation,
  output logic [2:0]          phase,
  output logic                monitoring
);
  import fdf_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_ROOT, B_APPLY} bstate_t;

  bstate_t   state;
  logic [1:0]  cur_op;
  logic [12:0] dev;
  logic [12:0] dev_calc;
  logic [12:0] ceil_root;
  sqrt_res_t   sq;
  logic        sq_start;
  logic        out_free;

  // detector state
  logic [2:0] detect_phase;
  logic [7:0] band_run;
  logic [7:0] impact_count;
  logic       impact_seen;
  logic [7:0] still_count;
  logic       still_moved;
  logic [7:0] recheck_count;
  logic       recheck_moved;
  logic       armed_flag;
  logic [3:0] seconds_elapsed;

  logic [2:0] detect_phase_next;
  logic [7:0] band_run_next;
  logic [7:0] impact_count_next;
  logic       impact_seen_next;
  logic [7:0] still_count_next;
  logic       still_moved_next;
  logic [7:0] recheck_count_next;
  logic       recheck_moved_next;
  logic       armed_flag_next;
  logic [3:0] seconds_elapsed_next;
  logic [2:0] ev_next;
  logic [3:0] shown_next;
  logic [12:0] dev_next;
  logic       inband;
  logic       fire;

  assign q_ready  = (state == B_IDLE);
  assign sq_start = (state == B_IDLE) && q_valid && (q_item.op == OP_SAMPLE);
  assign out_free = !out_valid || out_ready;

  fdf_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .n     (q_item.sumsq),
    .res   (sq)
  );

  // root rounded toward one g
  assign ceil_root = sq.exact ? sq.root : sq.root + 13'd1;
  assign dev_calc  = (sq.root >= ONE_G) ? sq.root - ONE_G : ONE_G - ceil_root;
  assign inband    = (dev >= cfg.band_low) && (dev <= cfg.band_high);

  always_comb begin
    detect_phase_next    = detect_phase;
    band_run_next        = band_run;
    impact_count_next    = impact_count;
    impact_seen_next     = impact_seen;
    still_count_next     = still_count;
    still_moved_next     = still_moved;
    recheck_count_next   = recheck_count;
    recheck_moved_next   = recheck_moved;
    armed_flag_next      = armed_flag;
    seconds_elapsed_next = seconds_elapsed;
    ev_next              = EV_NONE;
    shown_next           = '0;
    dev_next             = '0;
    fire                 = 1'b0;
    case (cur_op)
      OP_SAMPLE: begin
        dev_next = dev;
        case (detect_phase)
          PH_RUN: begin
            if (inband) begin
              band_run_next = inc8(band_run);
            end else if (band_run >= cfg.band_min_run) begin
              band_run_next     = '0;
              detect_phase_next = PH_IMPACT;
            end else begin
              band_run_next     = '0;
              detect_phase_next = PH_IDLE;
            end
          end
          PH_IMPACT: begin
          end
          PH_STILL: begin
            still_moved_next = still_moved || (dev >= cfg.still_threshold);
            still_count_next = inc8(still_count);
            if (still_count_next >= cfg.still_window) begin
              still_count_next = '0;
              if (still_moved_next) begin
                still_moved_next  = 1'b0;
                detect_phase_next = PH_RECHECK;
              end else begin
                fire = 1'b1;
              end
            end
          end
          PH_RECHECK: begin
            recheck_moved_next = recheck_moved || (dev >= cfg.still_threshold);
            recheck_count_next = inc8(recheck_count);
            if (recheck_count_next >= cfg.still_window) begin
              recheck_count_next = '0;
              if (recheck_moved_next) begin
                recheck_moved_next = 1'b0;
                detect_phase_next  = PH_IDLE;
              end else begin
                fire = 1'b1;
              end
            end
          end
          default: begin
            detect_phase_next = PH_IDLE;
            if (inband && armed_flag) begin
              detect_phase_next = PH_RUN;
              band_run_next     = inc8(band_run);
            end
          end
        endcase
        // impact window, also entered straight from the run phase
        if (detect_phase_next == PH_IMPACT) begin
          impact_seen_next  = impact_seen || (dev >= cfg.impact_threshold);
          impact_count_next = inc8(impact_count);
          if (impact_count_next >= cfg.impact_window) begin
            impact_count_next = '0;
            if (impact_seen_next) begin
              impact_seen_next  = 1'b0;
              detect_phase_next = PH_STILL;
            end else begin
              detect_phase_next = PH_IDLE;
            end
          end
        end
        if (fire) begin
          armed_flag_next      = 1'b0;
          seconds_elapsed_next = 4'd1;
          detect_phase_next    = PH_IDLE;
          ev_next              = EV_START;
          shown_next           = cfg.countdown_length;
        end
      end
      OP_TICK: begin
        if (!armed_flag) begin
          if (seconds_elapsed >= cfg.countdown_length) begin
            seconds_elapsed_next = '0;
            armed_flag_next      = 1'b1;
            ev_next              = EV_FALL;
          end else begin
            shown_next           = cfg.countdown_length - seconds_elapsed;
            seconds_elapsed_next = seconds_elapsed + 4'd1;
            ev_next              = EV_STEP;
          end
        end
      end
      OP_CANCEL: begin
        detect_phase_next    = PH_IDLE;
        band_run_next        = '0;
        impact_count_next    = '0;
        impact_seen_next     = 1'b0;
        still_count_next     = '0;
        still_moved_next     = 1'b0;
        recheck_count_next   = '0;
        recheck_moved_next   = 1'b0;
        armed_flag_next      = 1'b1;
        seconds_elapsed_next = '0;
        ev_next              = EV_CANCEL;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= B_IDLE;
      cur_op          <= OP_SAMPLE;
      dev             <= '0;
      out_valid       <= 1'b0;
      event_res       <= EV_NONE;
      countdown_shown <= '0;
      deviation       <= '0;
      phase           <= PH_IDLE;
      monitoring      <= 1'b1;
      detect_phase    <= PH_IDLE;
      band_run        <= '0;
      impact_count    <= '0;
      impact_seen     <= 1'b0;
      still_count     <= '0;
      still_moved     <= 1'b0;
      recheck_count   <= '0;
      recheck_moved   <= 1'b0;
      armed_flag      <= 1'b1;
      seconds_elapsed <= '0;
    end else begin
      // in the apply state the result register is loaded or kept full
      if (out_ready && (state != B_APPLY)) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            cur_op <= q_item.op;
            dev    <= '0;
            state  <= (q_item.op == OP_SAMPLE) ? B_ROOT : B_APPLY;
          end
        end
        B_ROOT: begin
          if (sq.done) begin
            dev   <= dev_calc;
            state <= B_APPLY;
          end
        end
        B_APPLY: begin
          // commit only once the result register has room
          if (out_free) begin
            detect_phase    <= detect_phase_next;
            band_run        <= band_run_next;
            impact_count    <= impact_count_next;
            impact_seen     <= impact_seen_next;
            still_count     <= still_count_next;
            still_moved     <= still_moved_next;
            recheck_count   <= recheck_count_next;
            recheck_moved   <= recheck_moved_next;
            armed_flag      <= armed_flag_next;
            seconds_elapsed <= seconds_elapsed_next;
            event_res       <= ev_next;
            countdown_shown <= shown_next;
            deviation       <= dev_next;
            phase           <= detect_phase_next;
            monitoring      <= armed_flag_next;
            out_valid       <= 1'b1;
            state           <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_countdown_idle: assert property (@(posedge clk) disable iff (rst)
    !armed_flag |-> (detect_phase == PH_IDLE))
    else $error("detector left idle during countdown");

  a_root_wait: assert property (@(posedge clk) disable iff (rst)
    sq.done |-> (state == B_ROOT))
    else $error("square root finished outside its wait state");

endmodule

>>> design/fall_detector_fsm_unit.sv
// ----------------------------------------------------------------------------
// fall_detector_fsm_unit
// accelerometer fall detector with countdown
// ----------------------------------------------------------------------------
// input stream s_axis: tuser carries the operation (sample, tick, cancel),
// tdata the three signed accelerations. each input transaction yields one
// result transaction on m_axis: tuser carries the event code, tdata the
// countdown value, the deviation from 1 g, the phase and the monitoring flag.
// registers are written over the cfg channel (always ready); the user must
// write them only while idle, the block does not enforce this. a sample goes
// through the front (three squares through one multiplier, then the push),
// the queue, then the back (entry, 13 steps of the square root unit,
// rounding, commit). the back sets the sustained sample rate; ticks and
// cancels skip the root and pass the front, queue and back apply state.
// the front and back are parted by a short queue, so the front keeps taking
// items while the back works or while a result waits in the output register.
// when m_axis stalls, the back holds its result and stops; the queue then
// fills and s_axis tready drops. reset clears the detector, arms it, and
// loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fall_detector_fsm_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // accel_x, accel_y, accel_z, zero pad
  input  logic [1:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // countdown_shown, deviation, phase, monitoring, pad
  output logic [2:0]  m_axis_tuser,  // event_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import fdf_pkg::*;

  cfg_t   cfg;
  qitem_t wr_item;
  qitem_t rd_item;
  logic   wr_valid;
  logic   wr_ready;
  logic   rd_valid;
  logic   rd_ready;

  logic [3:0]  countdown_shown;
  logic [12:0] deviation;
  logic [2:0]  phase;
  logic        monitoring;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.band_low         <= RST_BAND_LOW;
      cfg.band_high        <= RST_BAND_HIGH;
      cfg.band_min_run     <= RST_BAND_MIN_RUN;
      cfg.impact_threshold <= RST_IMPACT_THRESHOLD;
      cfg.impact_window    <= RST_IMPACT_WINDOW;
      cfg.still_threshold  <= RST_STILL_THRESHOLD;
      cfg.still_window     <= RST_STILL_WINDOW;
      cfg.countdown_length <= RST_COUNTDOWN_LENGTH;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BAND_LOW:         cfg.band_low         <= cfg_data;
        CFG_BAND_HIGH:        cfg.band_high        <= cfg_data;
        CFG_BAND_MIN_RUN:     cfg.band_min_run     <= cfg_data[7:0];
        CFG_IMPACT_THRESHOLD: cfg.impact_threshold <= cfg_data;
        CFG_IMPACT_WINDOW:    cfg.impact_window    <= cfg_data[7:0];
        CFG_STILL_THRESHOLD:  cfg.still_threshold  <= cfg_data;
        CFG_STILL_WINDOW:     cfg.still_window     <= cfg_data[7:0];
        CFG_COUNTDOWN_LENGTH: cfg.countdown_length <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  fdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .operation (s_axis_tuser),
    .accel_x   (s_axis_tdata[12:0]),
    .accel_y   (s_axis_tdata[25:13]),
    .accel_z   (s_axis_tdata[38:26]),
    .q_valid   (wr_valid),
    .q_ready   (wr_ready),
    .q_item    (wr_item)
  );

  fdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_item  (wr_item),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_item  (rd_item)
  );

  fdf_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (rd_valid),
    .q_ready         (rd_ready),
    .q_item          (rd_item),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .event_res       (m_axis_tuser),
    .countdown_shown (countdown_shown),
    .deviation       (deviation),
    .phase           (phase),
    .monitoring      (monitoring)
  );

  assign m_axis_tdata = {3'b000, monitoring, phase, deviation, countdown_shown};

endmodule

>>> tb/sv/tb_fall_detector_fsm_unit.sv
// ----------------------------------------------------------------------------
// tb_fall_detector_fsm_unit
// self-checking testbench of the fall detector with countdown
// ----------------------------------------------------------------------------
// items are queued by the stimulus process and sent in bursts on s_axis. an
// in-house model of the detector computes the result of every accepted item,
// and each m_axis transaction is checked field by field against the oldest
// expected result. the run goes through several register settings, with
// full fall sequences (free fall, impact, stillness, countdown) plus noise.
// ----------------------------------------------------------------------------
module tb_fall_detector_fsm_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fdf_pkg::*;

  // operation code outside the defined set, must be ignored
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [12:0] x;
    logic signed [12:0] y;
    logic signed [12:0] z;
  } accel_item_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [3:0]  shown;
    logic [12:0] dev;
    logic [2:0]  phase;
    logic        mon;
  } fall_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // accel_x, accel_y, accel_z, zero pad
  logic [1:0]  s_axis_tuser;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;   // countdown_shown, deviation, phase, monitoring, pad
  logic [2:0]  m_axis_tuser;   // event_res
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_BAND_LOW;
  logic [12:0] cfg_data = '0;

  accel_item_t  send_item = '0;
  accel_item_t  pending_items[$];
  fall_result_t due_results[$];

  int queued_count  = 0;
  int item_cap      = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int mismatch_count = 0;
  int start_count   = 0;
  int fall_count    = 0;
  int setting_count = 0;

  // register copies
  logic [12:0] cfg_band_low    = RST_BAND_LOW;
  logic [12:0] cfg_band_high   = RST_BAND_HIGH;
  logic [7:0]  cfg_min_run     = RST_BAND_MIN_RUN;
  logic [12:0] cfg_impact_thr  = RST_IMPACT_THRESHOLD;
  logic [7:0]  cfg_impact_win  = RST_IMPACT_WINDOW;
  logic [12:0] cfg_still_thr   = RST_STILL_THRESHOLD;
  logic [7:0]  cfg_still_win   = RST_STILL_WINDOW;
  logic [3:0]  cfg_countdown   = RST_COUNTDOWN_LENGTH;

  // detector state copies
  logic [2:0] det_phase = PH_IDLE;
  int         run_cnt = 0, impact_cnt = 0, still_cnt = 0, recheck_cnt = 0;
  bit         impact_hit = 0, still_move = 0, recheck_move = 0;
  bit         armed = 1;
  logic [3:0] secs_gone = '0;

  assign s_axis_tdata = {1'b0, send_item.z, send_item.y, send_item.x};
  assign s_axis_tuser = send_item.op;

  fall_detector_fsm_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int sat_inc(input int c);
    return (c >= 255) ? 255 : c + 1;
  endfunction

  function automatic fall_result_t predict_fall(input accel_item_t it);
    fall_result_t r;
    int         ax, ay, az, sq, root, trial, dev;
    logic [2:0] ph;
    bit         inband, fire;
    r = '0;
    fire = 0;
    case (it.op)
      OP_SAMPLE: begin
        ax = int'(it.x);
        ay = int'(it.y);
        az = int'(it.z);
        if (ax < 0) ax = -ax;
        if (ay < 0) ay = -ay;
        if (az < 0) az = -az;
        sq = ax * ax + ay * ay + az * az;
        root = 0;
        for (int b = 12; b >= 0; b--) begin
          trial = root | (1 << b);
          if (trial * trial <= sq) root = trial;
        end
        // root is pulled toward one g: up below it, down above it
        if (root >= int'(ONE_G)) begin
          dev = root - int'(ONE_G);
        end else begin
          dev = int'(ONE_G) - ((root * root == sq) ? root : root + 1);
        end
        inband = (dev >= int'(cfg_band_low)) && (dev <= int'(cfg_band_high));
        ph = det_phase;
        case (ph)
          PH_RUN: begin
            if (inband) begin
              run_cnt = sat_inc(run_cnt);
            end else if (run_cnt >= int'(cfg_min_run)) begin
              run_cnt = 0;
              ph = PH_IMPACT;
            end else begin
              run_cnt = 0;
              ph = PH_IDLE;
            end
          end
          PH_STILL: begin
            if (dev >= int'(cfg_still_thr)) still_move = 1;
            still_cnt = sat_inc(still_cnt);
            if (still_cnt >= int'(cfg_still_win)) begin
              still_cnt = 0;
              if (still_move) begin
                still_move = 0;
                ph = PH_RECHECK;
              end else begin
                fire = 1;
              end
            end
          end
          PH_RECHECK: begin
            if (dev >= int'(cfg_still_thr)) recheck_move = 1;
            recheck_cnt = sat_inc(recheck_cnt);
            if (recheck_cnt >= int'(cfg_still_win)) begin
              recheck_cnt = 0;
              if (recheck_move) begin
                recheck_move = 0;
                ph = PH_IDLE;
              end else begin
                fire = 1;
              end
            end
          end
          PH_IMPACT: ;
          default: begin
            ph = PH_IDLE;
            if (inband && armed) begin
              ph = PH_RUN;
              run_cnt = sat_inc(run_cnt);
            end
          end
        endcase
        // the sample that ends a free-fall run already counts in the impact window
        if (ph == PH_IMPACT) begin
          if (dev >= int'(cfg_impact_thr)) impact_hit = 1;
          impact_cnt = sat_inc(impact_cnt);
          if (impact_cnt >= int'(cfg_impact_win)) begin
            impact_cnt = 0;
            if (impact_hit) begin
              impact_hit = 0;
              ph = PH_STILL;
            end else begin
              ph = PH_IDLE;
            end
          end
        end
        if (fire) begin
          armed = 0;
          secs_gone = 4'd1;
          ph = PH_IDLE;
          r.ev = EV_START;
          r.shown = cfg_countdown;
          start_count++;
        end
        det_phase = ph;
        r.dev = dev[12:0];
      end
      OP_TICK: begin
        if (!armed) begin
          if (secs_gone >= cfg_countdown) begin
            secs_gone = '0;
            armed = 1;
            r.ev = EV_FALL;
            fall_count++;
          end else begin
            r.shown = cfg_countdown - secs_gone;
            secs_gone = secs_gone + 4'd1;
            r.ev = EV_STEP;
          end
        end
      end
      OP_CANCEL: begin
        det_phase = PH_IDLE;
        run_cnt = 0;
        impact_cnt = 0;
        impact_hit = 0;
        still_cnt = 0;
        still_move = 0;
        recheck_cnt = 0;
        recheck_move = 0;
        armed = 1;
        secs_gone = '0;
        r.ev = EV_CANCEL;
      end
      default: ;
    endcase
    r.phase = det_phase;
    r.mon = armed;
    return r;
  endfunction

  // sender: bursts of random length separated by random gaps
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin : feed_items
    logic take;
    take = 1'b0;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_results.push_back(predict_fall(send_item));
        accepted_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          take = 1'b1;
          send_item <= pending_items.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left--;
          end
        end
        s_axis_tvalid <= take;
      end
    end
  end

  // receiver: stall modes of random length
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin : stall_results
    logic rdy;
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 3) ? $urandom_range(1, 40) : $urandom_range(4, 60);
    end
    case (stall_mode)
      0: rdy = 1'b1;
      1: rdy = 1'($urandom_range(0, 1));
      2: rdy = (stall_left % 4) != 0;
      default: rdy = 1'b0;
    endcase
    m_axis_tready <= rst ? 1'b0 : rdy;
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    fall_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        $error("result transaction with no expected result: event %0d", m_axis_tuser);
        mismatch_count++;
      end else begin
        want = due_results.pop_front();
        check_field("event_res", want.ev, m_axis_tuser);
        check_field("countdown_shown", want.shown, m_axis_tdata[3:0]);
        check_field("deviation", want.dev, m_axis_tdata[16:4]);
        check_field("phase", want.phase, m_axis_tdata[19:17]);
        check_field("monitoring", want.mon, m_axis_tdata[20]);
        checked_count++;
      end
    end
  end

  function automatic accel_item_t pack_item(input logic [1:0] op,
                                            input int x, input int y, input int z);
    accel_item_t it;
    it.op = op;
    it.x = 13'(x);
    it.y = 13'(y);
    it.z = 13'(z);
    return it;
  endfunction

  task automatic push_item(input accel_item_t it);
    if (queued_count < item_cap) begin
      pending_items.push_back(it);
      queued_count++;
    end
  endtask

  // sample whose deviation lands in [lo, hi], along a random axis with jitter
  function automatic accel_item_t make_sample(input int lo, input int hi);
    int v[3];
    int d, m, axis;
    if (hi > 3000) hi = 3000;
    if (lo > hi) lo = hi;
    d = $urandom_range(hi, lo);
    m = (d > 1000 || $urandom_range(0, 1)) ? 1000 + d : 1000 - d;
    for (int i = 0; i < 3; i++) v[i] = int'($urandom_range(0, 6)) - 3;
    axis = $urandom_range(0, 2);
    v[axis] = $urandom_range(0, 1) ? m : -m;
    return pack_item(OP_SAMPLE, v[0], v[1], v[2]);
  endfunction

  function automatic accel_item_t noise_sample(input logic [1:0] op);
    return pack_item(op, int'($urandom_range(0, 8191)) - 4096,
                     int'($urandom_range(0, 8191)) - 4096,
                     int'($urandom_range(0, 8191)) - 4096);
  endfunction

  function automatic accel_item_t still_sample();
    if (cfg_still_thr == 0) return make_sample(0, 50);
    return make_sample(0, int'(cfg_still_thr) - 1);
  endfunction

  function automatic accel_item_t impact_sample();
    int lo;
    lo = (cfg_impact_thr > cfg_band_high) ? int'(cfg_impact_thr) : int'(cfg_band_high) + 1;
    return make_sample(lo, lo + 1500);
  endfunction

  // free fall, impact, two stillness windows, then the countdown
  task automatic queue_fall();
    int n;
    n = int'(cfg_min_run) + $urandom_range(0, 2);
    repeat (n) push_item(make_sample(cfg_band_low, cfg_band_high));
    if ($urandom_range(0, 9) == 0) push_item(noise_sample(OP_SAMPLE));
    push_item(impact_sample());
    for (int i = 1; i < int'(cfg_impact_win); i++) begin
      push_item(($urandom_range(0, 3) == 0) ? impact_sample() : still_sample());
    end
    // second window also feeds samples into a running countdown
    repeat (2) begin
      for (int i = 0; i < int'(cfg_still_win); i++) begin
        push_item(($urandom_range(0, 19) == 0) ? impact_sample() : still_sample());
      end
    end
    n = int'(cfg_countdown) + $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0) push_item(pack_item(OP_CANCEL, 0, 0, 0));
      else push_item(noise_sample(OP_TICK));
    end
  endtask

  task automatic queue_random(input int budget);
    int roll;
    item_cap = queued_count + budget;
    while (queued_count < item_cap) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        queue_fall();
      end else if (roll < 85) begin
        repeat ($urandom_range(1, 5)) push_item(noise_sample(OP_SAMPLE));
      end else if (roll < 92) begin
        push_item(noise_sample(OP_TICK));
      end else if (roll < 97) begin
        push_item(noise_sample(OP_CANCEL));
      end else begin
        push_item(noise_sample(OP_UNUSED));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || s_axis_tvalid || due_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic apply_settings(input logic [12:0] lo, input logic [12:0] hi,
                                input logic [7:0] run, input logic [12:0] thr,
                                input logic [7:0] win, input logic [12:0] sthr,
                                input logic [7:0] swin, input logic [3:0] cd);
    logic [12:0] vals [8];
    logic [2:0]  idx;
    vals = '{lo, hi, 13'(run), thr, 13'(win), sthr, 13'(swin), 13'(cd)};
    for (int i = 0; i < 8; i++) begin
      idx = 3'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        CFG_BAND_LOW:         cfg_band_low = vals[i];
        CFG_BAND_HIGH:        cfg_band_high = vals[i];
        CFG_BAND_MIN_RUN:     cfg_min_run = vals[i][7:0];
        CFG_IMPACT_THRESHOLD: cfg_impact_thr = vals[i];
        CFG_IMPACT_WINDOW:    cfg_impact_win = vals[i][7:0];
        CFG_STILL_THRESHOLD:  cfg_still_thr = vals[i];
        CFG_STILL_WINDOW:     cfg_still_win = vals[i][7:0];
        default:              cfg_countdown = vals[i][3:0];
      endcase
    end
    cfg_valid <= 1'b0;
    setting_count++;
  endtask

  initial begin : run_test
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed items at reset settings
    item_cap = 1 << 30;
    push_item(pack_item(OP_SAMPLE, 0, 0, 0));            // weightless, enters run
    push_item(pack_item(OP_SAMPLE, 4095, 4095, 4095));
    push_item(pack_item(OP_SAMPLE, -4096, -4096, -4096)); // largest magnitude
    push_item(pack_item(OP_SAMPLE, 600, 800, 0));        // exact one g
    push_item(pack_item(OP_SAMPLE, 999, 0, 0));
    push_item(pack_item(OP_SAMPLE, 1, 1, 1));            // inexact root rounds up
    push_item(pack_item(OP_SAMPLE, 0, -4096, 0));
    push_item(pack_item(OP_SAMPLE, 1001, 0, 0));
    push_item(pack_item(OP_SAMPLE, 577, 577, 577));      // root 999, not exact
    push_item(pack_item(OP_SAMPLE, -1, -1, -1));
    push_item(pack_item(OP_TICK, 0, 0, 0));              // tick while monitoring
    push_item(pack_item(OP_CANCEL, 4095, 4095, 4095));
    push_item(pack_item(OP_UNUSED, 4095, -1, -4096));
    push_item(pack_item(OP_TICK, -4096, -4096, -4096));
    push_item(pack_item(OP_UNUSED, 0, 0, 0));
    queue_random(200);
    wait_drained();

    apply_settings(13'd0, 13'd300, 8'd1, 13'd0, 8'd1, 13'd8191, 8'd1, 4'd1);
    queue_random(200);
    wait_drained();

    apply_settings(13'd700, 13'd1000, 8'd3, 13'd1500, 8'd6, 13'd150, 8'd8, 4'd15);
    queue_random(200);
    wait_drained();

    // everything in band: the run counter saturates
    apply_settings(13'd0, 13'd8191, 8'd255, 13'd8191, 8'd255, 13'd0, 8'd255, 4'd4);
    queue_random(300);
    wait_drained();

    apply_settings(13'd900, 13'd1100, 8'd2, 13'd300, 8'd3, 13'd50, 8'd5, 4'd3);
    queue_random(150);
    wait_drained();

    repeat (40) @(posedge clk);
    $display("%0d items accepted, %0d results checked over %0d register settings",
             accepted_count, checked_count, setting_count + 1);
    $display("%0d countdowns started, %0d falls reported", start_count, fall_count);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("fall_detector_fsm_unit regression: pass");
    end else begin
      $display("fall_detector_fsm_unit regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("fall_detector_fsm_unit regression: fail");
    $finish;
  end

endmodule

>>> fall_detector_fsm_unit.f
design/fdf_pkg.sv
design/fdf_front.sv
design/fdf_queue.sv
design/fdf_isqrt.sv
design/fdf_back.sv
design/fall_detector_fsm_unit.sv
tb/sv/tb_fall_detector_fsm_unit.sv
